@@ rtl/srsw_pkg.sv @@
`timescale 1ns / 1ps

package srsw_pkg;

   // Field widths
   localparam int MODE_W   = 3;
   localparam int SEQ_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;
   localparam int IVAL_W   = 16;
   localparam int FACTOR_W = 4;
   localparam int STAMP_W  = 32;
   localparam int CSR_A_W  = 2;
   localparam int CSR_D_W  = 16;
   localparam int PROD_W   = IVAL_W + FACTOR_W;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUSH       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ACK        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SACK       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POLL_ALL   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_POLL_FIRST = 3'd5;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STALE_ACK   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SACK_TAKEN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SACK_REJECT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RETRANSMIT  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE    = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_INIT_IVAL = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_BACKOFF   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MAX_IVAL  = 2'd2;

   // Configuration reset values
   localparam logic [IVAL_W-1:0]   INIT_IVAL_RST = 16'd500;
   localparam logic [FACTOR_W-1:0] BACKOFF_RST   = 4'd2;
   localparam logic [IVAL_W-1:0]   MAX_IVAL_RST  = 16'd8000;

endpackage

@@ rtl/srsw_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module srsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/selective_repeat_send_window.sv @@
`timescale 1ns / 1ps

// Selective-repeat send window. Holds up to WINDOW_SIZE in-flight sequence numbers, each with
// its own retransmit timer, in two small RAMs (sequence numbers; stamp and interval) plus
// valid and sacked flops. Every slot lookup walks the sequence RAM through its single read
// port, one slot per cycle, under one sequencer with one shared compare path. Push, SACK and
// a cumulative ACK above base walk the whole window before their response is offered; full
// pushes, stale ACKs, ticks and unknown modes go straight to the response. A poll repeats an
// ordered-minimum walk, with a timer check of each entry it finds, until no held entry
// is left or poll first finds one due; each entry it retransmits adds a timer write and a
// hand-off to the output register, which the response side can stall. req_stall is high for
// the whole transaction; the response sits in an output register so the next request can be
// taken while it waits.
// Poll all delivers each retransmit one step behind its discovery so that last is exact.
module selective_repeat_send_window #(
   parameter int WINDOW_SIZE = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [srsw_pkg::MODE_W-1:0]       req_mode,
   input  logic [srsw_pkg::SEQ_W-1:0]        req_seq_num,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [srsw_pkg::STATUS_W-1:0]     rsp_status,
   output logic [srsw_pkg::COUNT_W-1:0]      rsp_acked_count,
   output logic [srsw_pkg::SEQ_W-1:0]        rsp_resend_seq,
   output logic                              rsp_last,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [srsw_pkg::CSR_A_W-1:0]      csr_addr,
   input  logic [srsw_pkg::CSR_D_W-1:0]      csr_wr_data
);

   localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CW = $clog2(WINDOW_SIZE + 1);
   localparam int TW = srsw_pkg::STAMP_W + srsw_pkg::IVAL_W;
   localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW_SIZE);
   localparam logic [IW:0]   WIN_SUM = (IW + 1)'(WINDOW_SIZE);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHK,
      S_WRT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [srsw_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [srsw_pkg::SEQ_W-1:0]  key_ff, key_in;

   // scan pipeline
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          proc_vld_ff, proc_vld_in;
   logic [IW-1:0] proc_idx_ff, proc_idx_in;
   logic [IW:0]   wrap_sum;
   logic [IW-1:0] scan_idx;

   // window state
   logic [WINDOW_SIZE-1:0] valid_ff, valid_in;
   logic [WINDOW_SIZE-1:0] sacked_ff, sacked_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [CW-1:0]          entry_cnt_ff, entry_cnt_in;
   logic [srsw_pkg::SEQ_W-1:0]   base_ff, base_in;
   logic [srsw_pkg::STAMP_W-1:0] now_ff, now_in;

   // per-operation scratch
   logic          found_ff, found_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] ack_cnt_ff, ack_cnt_in;
   logic          best_found_ff, best_found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [srsw_pkg::SEQ_W-1:0] best_seq_ff, best_seq_in;
   logic          first_ff, first_in;
   logic [srsw_pkg::SEQ_W-1:0] prev_ff, prev_in;
   logic          held_vld_ff, held_vld_in;
   logic [srsw_pkg::SEQ_W-1:0] held_seq_ff, held_seq_in;
   logic [srsw_pkg::PROD_W-1:0] prod_ff, prod_in;

   // pending result
   logic [srsw_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [srsw_pkg::COUNT_W-1:0]  res_count_ff, res_count_in;
   logic [srsw_pkg::SEQ_W-1:0]    res_seq_ff, res_seq_in;
   logic                          res_last_ff, res_last_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [srsw_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [srsw_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [srsw_pkg::SEQ_W-1:0]    rsp_seq_ff, rsp_seq_in;
   logic                          rsp_last_ff, rsp_last_in;

   // configuration
   logic [srsw_pkg::IVAL_W-1:0]   init_ival_ff, init_ival_in;
   logic [srsw_pkg::FACTOR_W-1:0] backoff_ff, backoff_in;
   logic [srsw_pkg::IVAL_W-1:0]   max_ival_ff, max_ival_in;

   // RAM ports
   logic                       seq_we;
   logic [IW-1:0]              seq_waddr;
   logic [srsw_pkg::SEQ_W-1:0] seq_rd;
   logic                       tmr_we;
   logic [IW-1:0]              tmr_waddr;
   logic [TW-1:0]              tmr_wdata;
   logic [TW-1:0]              tmr_rd;

   logic                        req_take;
   logic                        out_free;
   logic [srsw_pkg::STAMP_W-1:0] elapsed;
   logic                        due;
   logic [srsw_pkg::IVAL_W-1:0] capped;
   logic [IW:0]                 head_sum;

   srsw_ram #(.WIDTH(srsw_pkg::SEQ_W), .DEPTH(WINDOW_SIZE)) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_we),
      .wr_addr (seq_waddr),
      .wr_data (key_ff),
      .rd_addr (scan_idx),
      .rd_data (seq_rd)
   );

   srsw_ram #(.WIDTH(TW), .DEPTH(WINDOW_SIZE)) u_tmr_ram (
      .clock   (clock),
      .wr_en   (tmr_we),
      .wr_addr (tmr_waddr),
      .wr_data (tmr_wdata),
      .rd_addr (best_idx_ff),
      .rd_data (tmr_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // scan address: pushes walk circularly from the head pointer
   always_comb begin
      wrap_sum = (IW + 1)'(head_ff) + (IW + 1)'(cnt_ff);
      if (wrap_sum >= WIN_SUM) begin
         wrap_sum = wrap_sum - WIN_SUM;
      end
      if (mode_ff == srsw_pkg::MODE_PUSH) begin
         scan_idx = wrap_sum[IW-1:0];
      end else begin
         scan_idx = IW'(cnt_ff);
      end
   end

   // timer check and backoff cap
   assign elapsed = now_ff - tmr_rd[TW-1:srsw_pkg::IVAL_W];
   assign due     = !sacked_ff[best_idx_ff] &&
                    (elapsed >= srsw_pkg::STAMP_W'(tmr_rd[srsw_pkg::IVAL_W-1:0]));
   assign capped  = (prod_ff > srsw_pkg::PROD_W'(max_ival_ff)) ? max_ival_ff
                                                               : prod_ff[srsw_pkg::IVAL_W-1:0];

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      valid_in      = valid_ff;
      sacked_in     = sacked_ff;
      head_in       = head_ff;
      entry_cnt_in  = entry_cnt_ff;
      base_in       = base_ff;
      now_in        = now_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      ack_cnt_in    = ack_cnt_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_seq_in   = best_seq_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      held_vld_in   = held_vld_ff;
      held_seq_in   = held_seq_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_seq_in    = res_seq_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_last_in   = rsp_last_ff;
      init_ival_in  = init_ival_ff;
      backoff_in    = backoff_ff;
      max_ival_in   = max_ival_ff;
      seq_we        = 1'b0;
      seq_waddr     = free_idx_ff;
      tmr_we        = 1'b0;
      tmr_waddr     = free_idx_ff;
      tmr_wdata     = {now_ff, init_ival_ff};
      head_sum      = (IW + 1)'(free_idx_ff) + (IW + 1)'(1);

      // configuration writes
      if (csr_wr_en) begin
         case (csr_addr)
            srsw_pkg::CSR_INIT_IVAL: init_ival_in = csr_wr_data;
            srsw_pkg::CSR_BACKOFF:   backoff_in   = csr_wr_data[srsw_pkg::FACTOR_W-1:0];
            srsw_pkg::CSR_MAX_IVAL:  max_ival_in  = csr_wr_data;
            default: ;
         endcase
      end

      // response register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in       = req_mode;
               key_in        = req_seq_num;
               cnt_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               ack_cnt_in    = '0;
               best_found_in = 1'b0;
               first_in      = 1'b1;
               prev_in       = '0;
               held_vld_in   = 1'b0;
               res_status_in = srsw_pkg::ST_OK;
               res_count_in  = '0;
               res_seq_in    = '0;
               res_last_in   = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
               case (req_mode)
                  srsw_pkg::MODE_PUSH: begin
                     if (entry_cnt_ff >= WIN_CNT) begin
                        res_status_in = srsw_pkg::ST_FULL;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  srsw_pkg::MODE_ACK: begin
                     if (req_seq_num <= base_ff) begin
                        res_status_in = srsw_pkg::ST_STALE_ACK;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  srsw_pkg::MODE_SACK,
                  srsw_pkg::MODE_POLL_ALL,
                  srsw_pkg::MODE_POLL_FIRST: begin
                     state_in = S_SCAN;
                  end
                  srsw_pkg::MODE_TICK: begin
                     now_in = now_ff + srsw_pkg::STAMP_W'(1);
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            // process the slot read last cycle
            if (proc_vld_ff) begin
               case (mode_ff)
                  srsw_pkg::MODE_PUSH: begin
                     if (valid_ff[proc_idx_ff] && seq_rd == key_ff) begin
                        found_in = 1'b1;
                     end
                     if (!valid_ff[proc_idx_ff] && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = proc_idx_ff;
                     end
                  end
                  srsw_pkg::MODE_ACK: begin
                     if (valid_ff[proc_idx_ff] && seq_rd < key_ff) begin
                        valid_in[proc_idx_ff]  = 1'b0;
                        sacked_in[proc_idx_ff] = 1'b0;
                        ack_cnt_in             = ack_cnt_ff + CW'(1);
                     end
                  end
                  srsw_pkg::MODE_SACK: begin
                     if (valid_ff[proc_idx_ff] && seq_rd == key_ff) begin
                        found_in   = 1'b1;
                        hit_idx_in = proc_idx_ff;
                     end
                  end
                  default: begin
                     // poll: smallest held number above the previous one
                     if (valid_ff[proc_idx_ff] && (first_ff || seq_rd > prev_ff) &&
                         (!best_found_ff || seq_rd < best_seq_ff)) begin
                        best_found_in = 1'b1;
                        best_idx_in   = proc_idx_ff;
                        best_seq_in   = seq_rd;
                     end
                  end
               endcase
            end

            // issue the next read, or wrap up the walk
            if (cnt_ff < WIN_CNT) begin
               proc_vld_in = 1'b1;
               proc_idx_in = scan_idx;
               cnt_in      = cnt_ff + CW'(1);
            end else if (!proc_vld_ff) begin
               res_status_in = srsw_pkg::ST_OK;
               res_count_in  = '0;
               res_seq_in    = '0;
               res_last_in   = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
               case (mode_ff)
                  srsw_pkg::MODE_PUSH: begin
                     if (!found_ff) begin
                        seq_we                  = 1'b1;
                        tmr_we                  = 1'b1;
                        valid_in[free_idx_ff]   = 1'b1;
                        sacked_in[free_idx_ff]  = 1'b0;
                        if (head_sum >= WIN_SUM) begin
                           head_sum = head_sum - WIN_SUM;
                        end
                        head_in      = head_sum[IW-1:0];
                        entry_cnt_in = entry_cnt_ff + CW'(1);
                     end
                  end
                  srsw_pkg::MODE_ACK: begin
                     entry_cnt_in = entry_cnt_ff - ack_cnt_ff;
                     base_in      = key_ff;
                     res_count_in = srsw_pkg::COUNT_W'(ack_cnt_ff);
                  end
                  srsw_pkg::MODE_SACK: begin
                     if (found_ff && !sacked_ff[hit_idx_ff]) begin
                        sacked_in[hit_idx_ff] = 1'b1;
                        res_status_in         = srsw_pkg::ST_SACK_TAKEN;
                     end else begin
                        res_status_in = srsw_pkg::ST_SACK_REJECT;
                     end
                  end
                  default: begin
                     if (best_found_ff) begin
                        prev_in  = best_seq_ff;
                        first_in = 1'b0;
                        state_in = S_CHK;
                     end else if (held_vld_ff) begin
                        res_status_in = srsw_pkg::ST_RETRANSMIT;
                        res_seq_in    = held_seq_ff;
                        held_vld_in   = 1'b0;
                     end else begin
                        res_status_in = srsw_pkg::ST_NONE_DUE;
                     end
                  end
               endcase
            end
         end

         // timer of the chosen slot is on the RAM output now
         S_CHK: begin
            if (due) begin
               prod_in  = srsw_pkg::PROD_W'(tmr_rd[srsw_pkg::IVAL_W-1:0]) *
                          srsw_pkg::PROD_W'(backoff_ff);
               state_in = S_WRT;
            end else begin
               cnt_in        = '0;
               best_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end

         // restart the timer with the backed-off interval
         S_WRT: begin
            tmr_we        = 1'b1;
            tmr_waddr     = best_idx_ff;
            tmr_wdata     = {now_ff, capped};
            cnt_in        = '0;
            best_found_in = 1'b0;
            res_status_in = srsw_pkg::ST_RETRANSMIT;
            res_count_in  = '0;
            if (mode_ff == srsw_pkg::MODE_POLL_FIRST) begin
               res_seq_in  = best_seq_ff;
               res_last_in = 1'b1;
               ret_in      = S_IDLE;
               state_in    = S_EMIT;
            end else if (held_vld_ff) begin
               res_seq_in  = held_seq_ff;
               res_last_in = 1'b0;
               held_seq_in = best_seq_ff;
               ret_in      = S_SCAN;
               state_in    = S_EMIT;
            end else begin
               held_vld_in = 1'b1;
               held_seq_in = best_seq_ff;
               state_in    = S_SCAN;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               rsp_seq_in    = res_seq_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ret_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         cnt_ff        <= '0;
         proc_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         sacked_ff     <= '0;
         head_ff       <= '0;
         entry_cnt_ff  <= '0;
         base_ff       <= '0;
         now_ff        <= '0;
         held_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         init_ival_ff  <= srsw_pkg::INIT_IVAL_RST;
         backoff_ff    <= srsw_pkg::BACKOFF_RST;
         max_ival_ff   <= srsw_pkg::MAX_IVAL_RST;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         cnt_ff        <= cnt_in;
         proc_vld_ff   <= proc_vld_in;
         valid_ff      <= valid_in;
         sacked_ff     <= sacked_in;
         head_ff       <= head_in;
         entry_cnt_ff  <= entry_cnt_in;
         base_ff       <= base_in;
         now_ff        <= now_in;
         held_vld_ff   <= held_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         init_ival_ff  <= init_ival_in;
         backoff_ff    <= backoff_in;
         max_ival_ff   <= max_ival_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      proc_idx_ff   <= proc_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      ack_cnt_ff    <= ack_cnt_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_seq_ff   <= best_seq_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      held_seq_ff   <= held_seq_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_seq_ff    <= res_seq_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_acked_count = rsp_count_ff;
   assign rsp_resend_seq  = rsp_seq_ff;
   assign rsp_last        = rsp_last_ff;

   // occupancy never exceeds the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_cnt_ff <= WIN_CNT)
      else $error("entry count above window size");

   // between transactions the count matches the valid bits
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == 32'(entry_cnt_ff)))
      else $error("entry count out of step with valid bits");

   // the timer check relies on the walk having just ended
   a_chk_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> ($past(state_ff) == S_SCAN))
      else $error("timer check without a preceding walk");

   // a held retransmit only exists during poll all
   a_held_mode: assert property (@(posedge clock) disable iff (reset)
      held_vld_ff |-> (mode_ff == srsw_pkg::MODE_POLL_ALL))
      else $error("held retransmit outside poll all");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS = 32;

   typedef struct {
      logic [srsw_pkg::STATUS_W-1:0] status;
      logic [srsw_pkg::COUNT_W-1:0]  acked_count;
      logic [srsw_pkg::SEQ_W-1:0]    resend_seq;
      logic                          last;
   } window_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [srsw_pkg::MODE_W-1:0]   req_mode = srsw_pkg::MODE_PUSH;
   logic [srsw_pkg::SEQ_W-1:0]    req_seq_num = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [srsw_pkg::STATUS_W-1:0] rsp_status;
   logic [srsw_pkg::COUNT_W-1:0]  rsp_acked_count;
   logic [srsw_pkg::SEQ_W-1:0]    rsp_resend_seq;
   logic                          rsp_last;
   logic                          csr_wr_en = 1'b0;
   logic [srsw_pkg::CSR_A_W-1:0]  csr_addr = srsw_pkg::CSR_INIT_IVAL;
   logic [srsw_pkg::CSR_D_W-1:0]  csr_wr_data = '0;

   // window shadow: configuration, slot table and clocks
   logic [srsw_pkg::IVAL_W-1:0]   cfg_init_rto;
   logic [srsw_pkg::FACTOR_W-1:0] cfg_backoff;
   logic [srsw_pkg::IVAL_W-1:0]   cfg_max_rto;
   bit                            slot_used [SLOTS];
   bit [srsw_pkg::SEQ_W-1:0]      slot_key [SLOTS];
   bit                            slot_marked [SLOTS];
   bit [srsw_pkg::STAMP_W-1:0]    slot_sent_at [SLOTS];
   bit [srsw_pkg::IVAL_W-1:0]     slot_rto [SLOTS];
   bit [4:0]                      push_head;
   int unsigned                   held_count;
   bit [srsw_pkg::SEQ_W-1:0]      ack_base;
   bit [srsw_pkg::STAMP_W-1:0]    wall_ms;

   window_rsp_type      pending_rsp [$];
   int unsigned         fail_count = 0;
   bit                  idle_on = 1'b1;
   bit                  long_hold_req = 1'b0;
   int unsigned         next_seq = 100;

   selective_repeat_send_window i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_seq_num(req_seq_num),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_acked_count(rsp_acked_count),
      .rsp_resend_seq(rsp_resend_seq), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("selective_repeat_send_window: mismatch");
      $finish;
   end

   // ---------------- shadow model ----------------
   function automatic void add_rsp(logic [srsw_pkg::STATUS_W-1:0] st,
                                   logic [srsw_pkg::COUNT_W-1:0] cnt,
                                   logic [srsw_pkg::SEQ_W-1:0] rs, logic lst);
      window_rsp_type r;
      r.status = st;
      r.acked_count = cnt;
      r.resend_seq = rs;
      r.last = lst;
      pending_rsp.push_back(r);
   endfunction

   function automatic int find_slot(bit [srsw_pkg::SEQ_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   // smallest held key above floor (or the smallest held key of all on the first step)
   function automatic int lowest_above(bit [srsw_pkg::SEQ_W-1:0] floor, bit first);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i]) continue;
         if (!first && slot_key[i] <= floor) continue;
         if (best < 0 || slot_key[i] < slot_key[best]) best = i;
      end
      return best;
   endfunction

   function automatic void predict_poll(bit all_due);
      int k;
      int idx;
      bit first;
      bit [srsw_pkg::SEQ_W-1:0] prev;
      bit [srsw_pkg::PROD_W-1:0] prod;
      k = 0;
      first = 1'b1;
      prev = '0;
      while (k < SLOTS) begin
         idx = lowest_above(prev, first);
         if (idx < 0) break;
         first = 1'b0;
         prev = slot_key[idx];
         if (slot_marked[idx] || (wall_ms - slot_sent_at[idx]) < slot_rto[idx]) continue;
         // restart timer with backed-off interval, capped
         prod = slot_rto[idx] * cfg_backoff;
         if (prod > cfg_max_rto) prod = cfg_max_rto;
         slot_sent_at[idx] = wall_ms;
         slot_rto[idx] = prod[srsw_pkg::IVAL_W-1:0];
         add_rsp(srsw_pkg::ST_RETRANSMIT, '0, slot_key[idx], 1'b0);
         k++;
         if (!all_due) break;
      end
      if (k == 0) add_rsp(srsw_pkg::ST_NONE_DUE, '0, '0, 1'b1);
      else pending_rsp[pending_rsp.size()-1].last = 1'b1;
   endfunction

   function automatic void predict_window(logic [srsw_pkg::MODE_W-1:0] m,
                                          bit [srsw_pkg::SEQ_W-1:0] s);
      int idx;
      int cnt;
      case (m)
         srsw_pkg::MODE_PUSH: begin
            if (held_count >= SLOTS) begin
               add_rsp(srsw_pkg::ST_FULL, '0, '0, 1'b1);
            end else begin
               if (find_slot(s) < 0) begin
                  idx = push_head;
                  for (int j = 0; j < SLOTS; j++) begin
                     idx = (push_head + j) % SLOTS;
                     if (!slot_used[idx]) break;
                  end
                  slot_used[idx] = 1'b1;
                  slot_key[idx] = s;
                  slot_marked[idx] = 1'b0;
                  slot_sent_at[idx] = wall_ms;
                  slot_rto[idx] = cfg_init_rto;
                  push_head = 5'(idx + 1);
                  held_count++;
               end
               add_rsp(srsw_pkg::ST_OK, '0, '0, 1'b1);
            end
         end
         srsw_pkg::MODE_ACK: begin
            if (s <= ack_base) begin
               add_rsp(srsw_pkg::ST_STALE_ACK, '0, '0, 1'b1);
            end else begin
               cnt = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (slot_used[i] && slot_key[i] < s) begin
                     slot_used[i] = 1'b0;
                     slot_marked[i] = 1'b0;
                     cnt++;
                  end
               held_count -= cnt;
               ack_base = s;
               add_rsp(srsw_pkg::ST_OK, srsw_pkg::COUNT_W'(cnt), '0, 1'b1);
            end
         end
         srsw_pkg::MODE_SACK: begin
            idx = find_slot(s);
            if (idx < 0 || slot_marked[idx]) begin
               add_rsp(srsw_pkg::ST_SACK_REJECT, '0, '0, 1'b1);
            end else begin
               slot_marked[idx] = 1'b1;
               add_rsp(srsw_pkg::ST_SACK_TAKEN, '0, '0, 1'b1);
            end
         end
         srsw_pkg::MODE_TICK: begin
            wall_ms++;
            add_rsp(srsw_pkg::ST_OK, '0, '0, 1'b1);
         end
         srsw_pkg::MODE_POLL_ALL:   predict_poll(1'b1);
         srsw_pkg::MODE_POLL_FIRST: predict_poll(1'b0);
         default:                   add_rsp(srsw_pkg::ST_OK, '0, '0, 1'b1);
      endcase
   endfunction

   // ---------------- drivers ----------------
   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_req(logic [srsw_pkg::MODE_W-1:0] m, logic [srsw_pkg::SEQ_W-1:0] s);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_seq_num <= s;
      do @(posedge clock); while (req_stall);
      predict_window(m, s);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // drives one write for a cycle; the caller drops the write enable afterwards
   task automatic write_csr(logic [srsw_pkg::CSR_A_W-1:0] idx,
                            logic [srsw_pkg::CSR_D_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         srsw_pkg::CSR_INIT_IVAL: cfg_init_rto = data;
         srsw_pkg::CSR_BACKOFF:   cfg_backoff = data[srsw_pkg::FACTOR_W-1:0];
         srsw_pkg::CSR_MAX_IVAL:  cfg_max_rto = data;
         default: ;
      endcase
   endtask

   task automatic set_timers(int unsigned init_ms, int unsigned factor, int unsigned cap_ms);
      drain();
      write_csr(srsw_pkg::CSR_INIT_IVAL, srsw_pkg::CSR_D_W'(init_ms));
      write_csr(srsw_pkg::CSR_BACKOFF, srsw_pkg::CSR_D_W'(factor));
      write_csr(srsw_pkg::CSR_MAX_IVAL, srsw_pkg::CSR_D_W'(cap_ms));
      csr_wr_en <= 1'b0;
   endtask

   // ---------------- response side ----------------
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      window_rsp_type exp_rsp;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected transaction: status %0d", rsp_status);
               fail_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_status);
                  fail_count++;
               end
               if (rsp_acked_count !== exp_rsp.acked_count) begin
                  $error("acked_count: expected %0d, actual %0d",
                         exp_rsp.acked_count, rsp_acked_count);
                  fail_count++;
               end
               if (rsp_resend_seq !== exp_rsp.resend_seq) begin
                  $error("resend_seq: expected %h, actual %h",
                         exp_rsp.resend_seq, rsp_resend_seq);
                  fail_count++;
               end
               if (rsp_last !== exp_rsp.last) begin
                  $error("last: expected %0d, actual %0d", exp_rsp.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed;
      send_req(srsw_pkg::MODE_POLL_FIRST, '0);         // empty window, nothing due
      send_req(srsw_pkg::MODE_PUSH, 32'd0);
      send_req(srsw_pkg::MODE_PUSH, 32'd1);
      send_req(srsw_pkg::MODE_PUSH, 32'hFFFF_FFFF);
      send_req(srsw_pkg::MODE_PUSH, 32'd1);            // duplicate keeps its timer
      send_req(srsw_pkg::MODE_SACK, 32'd1);
      send_req(srsw_pkg::MODE_SACK, 32'd1);            // already marked
      send_req(srsw_pkg::MODE_SACK, 32'hAAAA_5555);    // not held
      send_req(srsw_pkg::MODE_POLL_ALL, '0);
      send_req(srsw_pkg::MODE_TICK, '0);
      send_req(3'd6, 32'h5555_AAAA);                   // unknown modes
      send_req(3'd7, 32'hFFFF_FFFF);
      send_req(srsw_pkg::MODE_ACK, 32'd0);             // at base: stale
      send_req(srsw_pkg::MODE_ACK, 32'd2);
      send_req(srsw_pkg::MODE_ACK, 32'd2);
      send_req(srsw_pkg::MODE_SACK, 32'hFFFF_FFFF);
   endtask

   // fill the window past full while the receiver holds off
   task automatic test_window_full;
      set_timers(1, 8, 65535);
      long_hold_req = 1'b1;
      for (int i = 0; i < SLOTS + 2; i++) send_req(srsw_pkg::MODE_PUSH, next_seq + i);
      next_seq += SLOTS + 2;
      send_req(srsw_pkg::MODE_TICK, '0);
      send_req(srsw_pkg::MODE_POLL_ALL, '0);           // everything unmarked is due
      send_req(srsw_pkg::MODE_POLL_FIRST, '0);
      send_req(srsw_pkg::MODE_ACK, next_seq - 16);
   endtask

   task automatic random_item;
      int unsigned pick;
      logic [srsw_pkg::SEQ_W-1:0] s;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         if ($urandom_range(0, 19) == 0) s = $urandom();
         else if ($urandom_range(0, 9) == 0) s = next_seq - $urandom_range(1, 4);
         else begin
            next_seq += $urandom_range(1, 2);
            s = next_seq;
         end
         send_req(srsw_pkg::MODE_PUSH, s);
      end else if (pick < 42) begin
         if ($urandom_range(0, 5) == 0) s = ack_base - $urandom_range(0, 3);
         else s = ack_base + $urandom_range(1, (next_seq > ack_base) ?
                                            (next_seq - ack_base) / 2 + 2 : 2);
         send_req(srsw_pkg::MODE_ACK, s);
      end else if (pick < 57) begin
         s = ($urandom_range(0, 7) == 0) ? $urandom() : next_seq - $urandom_range(0, 12);
         send_req(srsw_pkg::MODE_SACK, s);
      end else if (pick < 80) begin
         send_req(srsw_pkg::MODE_TICK, $urandom());
      end else if (pick < 88) begin
         send_req(srsw_pkg::MODE_POLL_ALL, $urandom());
      end else if (pick < 96) begin
         send_req(srsw_pkg::MODE_POLL_FIRST, $urandom());
      end else begin
         send_req(srsw_pkg::MODE_W'($urandom_range(6, 7)), $urandom());
      end
   endtask

   task automatic test_random(int unsigned init_ms, int unsigned factor,
                              int unsigned cap_ms, int unsigned n_items);
      set_timers(init_ms, factor, cap_ms);
      repeat (n_items) random_item();
   endtask

   task automatic test_ack_top;
      send_req(srsw_pkg::MODE_POLL_ALL, '0);
      send_req(srsw_pkg::MODE_ACK, 32'hFFFF_FFFF);
      send_req(srsw_pkg::MODE_ACK, 32'hFFFF_FFFF);
   endtask

   initial begin
      cfg_init_rto = srsw_pkg::INIT_IVAL_RST;
      cfg_backoff = srsw_pkg::BACKOFF_RST;
      cfg_max_rto = srsw_pkg::MAX_IVAL_RST;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_marked[i] = 1'b0;
      end
      push_head = '0;
      held_count = 0;
      ack_base = '0;
      wall_ms = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_window_full();
      test_random(1, 1, 1, 65);
      test_random(2, 8, 65535, 65);
      test_random(3, 2, 10, 65);
      test_random(65535, 8, 65535, 55);
      idle_on = 1'b0;
      test_random(1, 3, 7, 70);
      test_ack_top();

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("selective_repeat_send_window: match");
      end else begin
         $display("selective_repeat_send_window: mismatch");
      end
      $finish;
   end

endmodule
